>>> sv/gma_pkg.sv
// shared constants and types for the greedy machine assigner
package gma_pkg;

   // default sizing
   localparam int MAX_MACHINES_DEF = 16;
   localparam int TIME_BITS_DEF    = 32;

   // fixed field widths
   localparam int JOB_BITS      = 16;
   localparam int ID_OUT_BITS   = 5;
   localparam int TIME_OUT_BITS = 32;
   localparam int COUNT_BITS    = 5;

   // machine count after reset
   localparam int RESET_COUNT = 3;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_DOWN,
      ST_PLACE,
      ST_PUSH,
      ST_UP,
      ST_PUT,
      ST_DONE
   } state_type;

endpackage

>>> sv/gma_req_if.sv
// job request channel
interface gma_req_if;
   logic                         valid;
   logic                         ready;
   logic [gma_pkg::JOB_BITS-1:0] job_length;

   modport source (output valid, output job_length, input ready);
   modport sink (input valid, input job_length, output ready);
endinterface

>>> sv/gma_rsp_if.sv
// assignment result channel
interface gma_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [gma_pkg::ID_OUT_BITS-1:0]   machine_id;
   logic [gma_pkg::TIME_OUT_BITS-1:0] start_time;
   logic [gma_pkg::TIME_OUT_BITS-1:0] end_time;
   logic                              time_saturated;

   modport source (output valid, output machine_id, output start_time, output end_time,
                   output time_saturated, input ready);
   modport sink (input valid, input machine_id, input start_time, input end_time,
                 input time_saturated, output ready);
endinterface

>>> sv/gma_heap_mem.sv
// heap slot memory: two registered read ports, one write port, per-slot valid bits
module gma_heap_mem #(
   parameter int DEPTH     = gma_pkg::MAX_MACHINES_DEF,
   parameter int TIME_BITS = gma_pkg::TIME_BITS_DEF,
   localparam int IDX_BITS  = $clog2(DEPTH + 1),
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   input  logic [IDX_BITS-1:0]  rd_a_idx,
   input  logic [IDX_BITS-1:0]  rd_b_idx,
   input  logic                 wr_en,
   input  logic [IDX_BITS-1:0]  wr_idx,
   input  logic [IDX_BITS-1:0]  wr_id,
   input  logic [TIME_BITS-1:0] wr_t,
   output logic [IDX_BITS-1:0]  rd_a_id,
   output logic [TIME_BITS-1:0] rd_a_t,
   output logic [IDX_BITS-1:0]  rd_b_id,
   output logic [TIME_BITS-1:0] rd_b_t
);

   localparam int ENTRY_BITS = IDX_BITS + TIME_BITS;

   logic [ENTRY_BITS-1:0] heap_mem [DEPTH];
   logic [DEPTH-1:0]      valid_ff;
   logic [ENTRY_BITS-1:0] a_data_ff, b_data_ff;
   logic                  a_valid_ff, b_valid_ff;
   logic [IDX_BITS-1:0]   a_idx_ff, b_idx_ff;

   logic [IDX_BITS-1:0]   wr_m1, a_m1, b_m1;
   logic [ADDR_BITS-1:0]  wr_addr, a_addr, b_addr;

   // slot numbers start at one
   assign wr_m1   = wr_idx - 1'b1;
   assign a_m1    = rd_a_idx - 1'b1;
   assign b_m1    = rd_b_idx - 1'b1;
   assign wr_addr = wr_m1[ADDR_BITS-1:0];
   assign a_addr  = a_m1[ADDR_BITS-1:0];
   assign b_addr  = b_m1[ADDR_BITS-1:0];

   // storage write and registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= {wr_id, wr_t};
      end
      a_data_ff <= heap_mem[a_addr];
      b_data_ff <= heap_mem[b_addr];
      a_idx_ff  <= rd_a_idx;
      b_idx_ff  <= rd_b_idx;
   end

   // valid bits, cleared on reset and on re-init
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff   <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         a_valid_ff <= valid_ff[a_addr];
         b_valid_ff <= valid_ff[b_addr];
      end
   end

   // an unwritten slot k holds machine k at time zero
   always_comb begin
      if (a_valid_ff) begin
         {rd_a_id, rd_a_t} = a_data_ff;
      end else begin
         rd_a_id = a_idx_ff;
         rd_a_t  = '0;
      end
      if (b_valid_ff) begin
         {rd_b_id, rd_b_t} = b_data_ff;
      end else begin
         rd_b_id = b_idx_ff;
         rd_b_t  = '0;
      end
   end

endmodule

>>> sv/greedy_machine_assigner.sv
// top level: heap sequencer, time arithmetic and result register
//
//  channel | direction | handshake          | word
//  req_bus | in        | valid / ready      | job_length
//  rsp_bus | out       | valid / ready      | machine_id, start_time, end_time, time_saturated
//  csr     | in        | csr_wr_en          | machine_count (csr_wr_data)
//
// One job at a time: a job is taken only in idle, then passes through pop, the sift-down
// levels and a placement at the bottom where needed, push, the sift-up compares and a root
// write where needed, and done, where its word is registered on rsp_bus as the block returns
// to idle to take the next job. With one machine the push writes the root directly.
// Reset and a count write clear per-slot valid bits at once; no clearing pass is needed.
// A result waiting on rsp_bus holds the next job only in its done state.
module greedy_machine_assigner #(
   parameter int MAX_MACHINES = gma_pkg::MAX_MACHINES_DEF,
   parameter int TIME_BITS    = gma_pkg::TIME_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   gma_req_if.sink                          req_bus,
   gma_rsp_if.source                        rsp_bus,
   input  logic                             csr_wr_en,
   input  logic [gma_pkg::COUNT_BITS-1:0]   csr_wr_data
);

   localparam int IDX_BITS  = $clog2(MAX_MACHINES + 1);
   localparam int CMP_BITS  = (IDX_BITS > gma_pkg::COUNT_BITS) ? IDX_BITS : gma_pkg::COUNT_BITS;
   localparam int RST_COUNT = (gma_pkg::RESET_COUNT > MAX_MACHINES) ? MAX_MACHINES
                                                                     : gma_pkg::RESET_COUNT;
   localparam int JB  = gma_pkg::JOB_BITS;
   localparam int IOB = gma_pkg::ID_OUT_BITS;
   localparam int TOB = gma_pkg::TIME_OUT_BITS;

   gma_pkg::state_type state_ff, state_in;

   logic [IDX_BITS-1:0]  count_ff, count_in;
   logic [JB-1:0]        len_ff, len_in;
   logic [IDX_BITS-1:0]  parent_ff, parent_in;
   logic [IDX_BITS-1:0]  child_ff, child_in;
   logic [IDX_BITS-1:0]  pos_ff, pos_in;
   logic [IDX_BITS-1:0]  last_id_ff, last_id_in;
   logic [TIME_BITS-1:0] last_t_ff, last_t_in;
   logic [IDX_BITS-1:0]  e_id_ff, e_id_in;
   logic [TIME_BITS-1:0] e_t_ff, e_t_in;
   logic [IOB-1:0]       res_id_ff, res_id_in;
   logic [TOB-1:0]       res_start_ff, res_start_in;
   logic [TOB-1:0]       res_end_ff, res_end_in;
   logic                 res_sat_ff, res_sat_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IOB-1:0]       rsp_id_ff, rsp_id_in;
   logic [TOB-1:0]       rsp_start_ff, rsp_start_in;
   logic [TOB-1:0]       rsp_end_ff, rsp_end_in;
   logic                 rsp_sat_ff, rsp_sat_in;

   // memory port signals
   logic [IDX_BITS-1:0]  rd_a_idx, rd_b_idx, wr_idx, wr_id;
   logic [IDX_BITS-1:0]  rd_a_id, rd_b_id;
   logic [TIME_BITS-1:0] rd_a_t, rd_b_t, wr_t;
   logic                 wr_en;

   gma_heap_mem #(
      .DEPTH     (MAX_MACHINES),
      .TIME_BITS (TIME_BITS)
   ) u_heap_mem (
      .clock    (clock),
      .reset    (reset),
      .clear    (csr_wr_en),
      .rd_a_idx (rd_a_idx),
      .rd_b_idx (rd_b_idx),
      .wr_en    (wr_en),
      .wr_idx   (wr_idx),
      .wr_id    (wr_id),
      .wr_t     (wr_t),
      .rd_a_id  (rd_a_id),
      .rd_a_t   (rd_a_t),
      .rd_b_id  (rd_b_id),
      .rd_b_t   (rd_b_t)
   );

   // clamp the written count into 1..MAX_MACHINES
   logic [CMP_BITS-1:0] csr_wide;
   assign csr_wide = CMP_BITS'(csr_wr_data);

   always_comb begin
      if (csr_wide == '0) begin
         count_in = IDX_BITS'(1);
      end else if (csr_wide > CMP_BITS'(MAX_MACHINES)) begin
         count_in = IDX_BITS'(MAX_MACHINES);
      end else begin
         count_in = csr_wide[IDX_BITS-1:0];
      end
   end

   // heap size while the root is out
   logic [IDX_BITS-1:0] hlen;
   assign hlen = count_ff - 1'b1;

   // new free time and last tick of the job, both saturating
   logic [TIME_BITS:0]   sum_w, end_w;
   logic [TIME_BITS-1:0] new_t, end_t;
   logic                 sat;
   assign sum_w = {1'b0, rd_a_t} + {{(TIME_BITS + 1 - JB){1'b0}}, len_ff};
   assign end_w = sum_w - 1'b1;
   assign sat   = sum_w[TIME_BITS];
   assign new_t = sat ? '1 : sum_w[TIME_BITS-1:0];
   assign end_t = (len_ff == '0) ? rd_a_t : (end_w[TIME_BITS] ? '1 : end_w[TIME_BITS-1:0]);

   // output-width views of id and times
   logic [IDX_BITS+IOB-1:0]  id_ext;
   logic [TIME_BITS+TOB-1:0] start_ext, end_ext;
   assign id_ext    = {{IOB{1'b0}}, rd_a_id};
   assign start_ext = {{TOB{1'b0}}, rd_a_t};
   assign end_ext   = {{TOB{1'b0}}, end_t};

   // sift-down child choice and next child pair
   logic                 take_right;
   logic [IDX_BITS-1:0]  sel, child_p1;
   logic [IDX_BITS-1:0]  pick_id;
   logic [TIME_BITS-1:0] pick_t;
   logic [IDX_BITS:0]    next_child, next_child_p1;
   assign take_right    = (child_ff < hlen) && (rd_a_t > rd_b_t);
   assign child_p1      = child_ff + 1'b1;
   assign sel           = take_right ? child_p1 : child_ff;
   assign pick_id       = take_right ? rd_b_id : rd_a_id;
   assign pick_t        = take_right ? rd_b_t : rd_a_t;
   assign next_child    = {sel, 1'b0};
   assign next_child_p1 = next_child + 1'b1;

   // sift-up parent position
   logic [IDX_BITS-1:0] pos_half;
   assign pos_half = pos_ff >> 1;

   // state and data registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gma_pkg::ST_IDLE;
         count_ff     <= IDX_BITS'(RST_COUNT);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            count_ff <= count_in;
         end
      end
      len_ff       <= len_in;
      parent_ff    <= parent_in;
      child_ff     <= child_in;
      pos_ff       <= pos_in;
      last_id_ff   <= last_id_in;
      last_t_ff    <= last_t_in;
      e_id_ff      <= e_id_in;
      e_t_ff       <= e_t_in;
      res_id_ff    <= res_id_in;
      res_start_ff <= res_start_in;
      res_end_ff   <= res_end_in;
      res_sat_ff   <= res_sat_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_start_ff <= rsp_start_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   // sequencer: pop root, sift down the last slot, push updated machine, sift up
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      parent_in    = parent_ff;
      child_in     = child_ff;
      pos_in       = pos_ff;
      last_id_in   = last_id_ff;
      last_t_in    = last_t_ff;
      e_id_in      = e_id_ff;
      e_t_in       = e_t_ff;
      res_id_in    = res_id_ff;
      res_start_in = res_start_ff;
      res_end_in   = res_end_ff;
      res_sat_in   = res_sat_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_start_in = rsp_start_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      req_bus.ready = 1'b0;
      rd_a_idx     = IDX_BITS'(1);
      rd_b_idx     = count_ff;
      wr_en        = 1'b0;
      wr_idx       = parent_ff;
      wr_id        = last_id_ff;
      wr_t         = last_t_ff;

      case (state_ff)
         gma_pkg::ST_IDLE: begin
            // root and last slot are read while idle
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               len_in   = req_bus.job_length;
               state_in = gma_pkg::ST_POP;
            end
         end
         gma_pkg::ST_POP: begin
            res_id_in    = id_ext[IOB-1:0];
            res_start_in = start_ext[TOB-1:0];
            res_end_in   = end_ext[TOB-1:0];
            res_sat_in   = sat;
            e_id_in      = rd_a_id;
            e_t_in       = new_t;
            last_id_in   = rd_b_id;
            last_t_in    = rd_b_t;
            parent_in    = IDX_BITS'(1);
            if (hlen >= IDX_BITS'(2)) begin
               rd_a_idx = IDX_BITS'(2);
               rd_b_idx = IDX_BITS'(3);
               child_in = IDX_BITS'(2);
               state_in = gma_pkg::ST_DOWN;
            end else begin
               state_in = gma_pkg::ST_PLACE;
            end
         end
         gma_pkg::ST_DOWN: begin
            wr_en = 1'b1;
            if (last_t_ff < pick_t) begin
               state_in = gma_pkg::ST_PUSH;
            end else begin
               wr_id     = pick_id;
               wr_t      = pick_t;
               parent_in = sel;
               if (next_child <= {1'b0, hlen}) begin
                  rd_a_idx = next_child[IDX_BITS-1:0];
                  rd_b_idx = next_child_p1[IDX_BITS-1:0];
                  child_in = next_child[IDX_BITS-1:0];
               end else begin
                  state_in = gma_pkg::ST_PLACE;
               end
            end
         end
         gma_pkg::ST_PLACE: begin
            wr_en    = 1'b1;
            state_in = gma_pkg::ST_PUSH;
         end
         gma_pkg::ST_PUSH: begin
            pos_in   = count_ff;
            rd_a_idx = count_ff >> 1;
            if (count_ff == IDX_BITS'(1)) begin
               wr_en    = 1'b1;
               wr_idx   = IDX_BITS'(1);
               wr_id    = e_id_ff;
               wr_t     = e_t_ff;
               state_in = gma_pkg::ST_DONE;
            end else begin
               state_in = gma_pkg::ST_UP;
            end
         end
         gma_pkg::ST_UP: begin
            wr_en  = 1'b1;
            wr_idx = pos_ff;
            if (e_t_ff < rd_a_t) begin
               wr_id    = rd_a_id;
               wr_t     = rd_a_t;
               pos_in   = pos_half;
               rd_a_idx = pos_half >> 1;
               if (pos_half == IDX_BITS'(1)) begin
                  state_in = gma_pkg::ST_PUT;
               end
            end else begin
               wr_id    = e_id_ff;
               wr_t     = e_t_ff;
               state_in = gma_pkg::ST_DONE;
            end
         end
         gma_pkg::ST_PUT: begin
            wr_en    = 1'b1;
            wr_idx   = IDX_BITS'(1);
            wr_id    = e_id_ff;
            wr_t     = e_t_ff;
            state_in = gma_pkg::ST_DONE;
         end
         gma_pkg::ST_DONE: begin
            // hand the word to the output register once it is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = res_id_ff;
               rsp_start_in = res_start_ff;
               rsp_end_in   = res_end_ff;
               rsp_sat_in   = res_sat_ff;
               state_in     = gma_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gma_pkg::ST_IDLE;
         end
      endcase
   end

   // result channel outputs
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.machine_id     = rsp_id_ff;
   assign rsp_bus.start_time     = rsp_start_ff;
   assign rsp_bus.end_time       = rsp_end_ff;
   assign rsp_bus.time_saturated = rsp_sat_ff;

endmodule

>>> verif/testbench.sv
// testbench for the greedy machine assigner: heap scoreboard, job and result drivers, checks
`timescale 1ns / 1ps

// one heap entry: machine number and the time it is next free
typedef struct {
   logic [gma_pkg::ID_OUT_BITS-1:0] machine;
   logic [63:0]                     free_at;
} machine_slot_type;

// one predicted result word
typedef struct {
   logic [gma_pkg::ID_OUT_BITS-1:0]   machine_id;
   logic [gma_pkg::TIME_OUT_BITS-1:0] start_time;
   logic [gma_pkg::TIME_OUT_BITS-1:0] end_time;
   logic                              time_saturated;
} assignment_type;

class schedule_board;
   localparam int          MACHINES = gma_pkg::MAX_MACHINES_DEF;
   localparam logic [63:0] TIME_MAX = (64'd1 << gma_pkg::TIME_BITS_DEF) - 64'd1;

   machine_slot_type slots[MACHINES + 1];
   int unsigned      fill;
   assignment_type   due_assignments[$];
   int unsigned      mismatches;

   function new();
      mismatches = 0;
      load_count(gma_pkg::COUNT_BITS'(gma_pkg::RESET_COUNT));
   endfunction

   // count write: clamp to 1..MACHINES, all machines free at time zero
   function void load_count(input logic [gma_pkg::COUNT_BITS-1:0] value);
      int unsigned n;
      n = value;
      if (n < 1) n = 1;
      if (n > MACHINES) n = MACHINES;
      for (int k = 0; k <= MACHINES; k++) begin
         slots[k].machine = (k >= 1 && k <= n) ? gma_pkg::ID_OUT_BITS'(k) : '0;
         slots[k].free_at = 64'd0;
      end
      fill = n;
   endfunction

   // take the root; left child wins ties, moved entry stops only when strictly less
   function machine_slot_type pop_earliest();
      machine_slot_type top;
      machine_slot_type tail;
      int unsigned      parent;
      int unsigned      child;
      top    = slots[1];
      tail   = slots[fill];
      fill   = fill - 1;
      parent = 1;
      child  = 2;
      while (child <= fill) begin
         if (child < fill && slots[child].free_at > slots[child + 1].free_at) child++;
         if (tail.free_at < slots[child].free_at) break;
         slots[parent] = slots[child];
         parent = child;
         child  = child * 2;
      end
      slots[parent] = tail;
      return top;
   endfunction

   // append and sift up while strictly less than the parent
   function void push_back_machine(input machine_slot_type entry);
      int unsigned i;
      fill = fill + 1;
      i    = fill;
      while (i != 1 && entry.free_at < slots[i / 2].free_at) begin
         slots[i] = slots[i / 2];
         i = i / 2;
      end
      slots[i] = entry;
   endfunction

   // accepted job word: predict its assignment and update the heap
   function void note_job(input logic [gma_pkg::JOB_BITS-1:0] length);
      machine_slot_type chosen;
      assignment_type   want;
      logic [63:0]      start;
      logic [63:0]      room;
      logic [63:0]      span;
      logic [63:0]      freed;
      logic [63:0]      last_tick;
      logic             clipped;
      chosen  = pop_earliest();
      span    = {48'd0, length};
      start   = chosen.free_at & TIME_MAX;
      room    = TIME_MAX - start;
      clipped = 1'b0;
      if (span > room) begin
         freed   = TIME_MAX;
         clipped = 1'b1;
      end else begin
         freed = start + span;
      end
      // zero length ends where it starts
      if (span == 64'd0) last_tick = start;
      else if (span - 64'd1 > room) last_tick = TIME_MAX;
      else last_tick = start + span - 64'd1;
      want.machine_id     = chosen.machine;
      want.start_time     = start[gma_pkg::TIME_OUT_BITS-1:0];
      want.end_time       = last_tick[gma_pkg::TIME_OUT_BITS-1:0];
      want.time_saturated = clipped;
      due_assignments.push_back(want);
      chosen.free_at = freed;
      push_back_machine(chosen);
   endfunction

   // accepted result word: compare with the oldest prediction
   function void check_assignment(input logic [gma_pkg::ID_OUT_BITS-1:0]   machine_id,
                                  input logic [gma_pkg::TIME_OUT_BITS-1:0] start_time,
                                  input logic [gma_pkg::TIME_OUT_BITS-1:0] end_time,
                                  input logic                              time_saturated);
      assignment_type want;
      if (due_assignments.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result: machine %0d start %0d end %0d sat %0b",
                     machine_id, start_time, end_time, time_saturated);
         return;
      end
      want = due_assignments.pop_front();
      if (machine_id !== want.machine_id || start_time !== want.start_time ||
          end_time !== want.end_time || time_saturated !== want.time_saturated) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected machine %0d start %0d end %0d sat %0b, got %0d %0d %0d %0b",
                     want.machine_id, want.start_time, want.end_time, want.time_saturated,
                     machine_id, start_time, end_time, time_saturated);
      end
   endfunction

   function int unsigned pending_count();
      return due_assignments.size();
   endfunction
endclass

module testbench;
   localparam int QUIET_LIMIT   = 3000;
   localparam int SETTLE_CYCLES = 20;
   localparam int HOLD_CYCLES   = 250;
   localparam int PHASE_ITEMS   = 50;
   localparam int PHASE_COUNTS [8] = '{2, 16, 1, 5, 17, 7, 16, 3};

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [gma_pkg::COUNT_BITS-1:0] csr_wr_data;

   gma_req_if req_bus();
   gma_rsp_if rsp_bus();

   schedule_board board = new();

   bit                          req_idle_on;
   bit                          rsp_idle_on;
   int                          hold_off;
   int                          quiet_cycles;
   logic [gma_pkg::JOB_BITS-1:0] last_length;

   greedy_machine_assigner uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // clock
   always #5 clock = ~clock;

   function automatic int draw_gap(input bit enabled);
      return enabled ? $urandom_range(0, 18) : 0;
   endfunction

   // mostly full range, some small, extremes and repeats for equal free times
   function automatic logic [gma_pkg::JOB_BITS-1:0] pick_length();
      case ($urandom_range(0, 9))
         0: pick_length = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
         1, 2: pick_length = 16'($urandom_range(0, 15));
         3: pick_length = last_length;
         default: pick_length = 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // offer one job word, called and left at a falling edge
   task automatic send_job(input logic [gma_pkg::JOB_BITS-1:0] length);
      int gap;
      gap = draw_gap(req_idle_on);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.job_length <= length;
      last_length = length;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // wait for the block to go idle, then write the machine count
   task automatic set_machine_count(input logic [gma_pkg::COUNT_BITS-1:0] value);
      req_bus.valid <= 1'b0;
      while (board.pending_count() > 0) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      board.load_count(value);
   endtask

   // result side: random gaps, plus one long hold-off on request
   initial begin
      int gap;
      rsp_bus.ready = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         if (hold_off > 0) begin
            gap      = hold_off;
            hold_off = 0;
         end else begin
            gap = draw_gap(rsp_idle_on);
         end
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         @(negedge clock);
      end
   end

   // handshake monitor
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         board.note_job(req_bus.job_length);
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.check_assignment(rsp_bus.machine_id, rsp_bus.start_time,
                                rsp_bus.end_time, rsp_bus.time_saturated);
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      int                             phase;
      int                             k;
      logic [gma_pkg::COUNT_BITS-1:0] count_value;
      clock              = 1'b0;
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_bus.valid      = 1'b0;
      req_bus.job_length = '0;
      req_idle_on        = 1'b1;
      rsp_idle_on        = 1'b1;
      hold_off           = 0;
      quiet_cycles       = 0;
      last_length        = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // three machines out of reset: extremes, zero length, alternating bits
      send_job(16'd1);
      send_job(16'hFFFF);
      send_job(16'd0);
      send_job(16'h5555);
      send_job(16'hAAAA);
      send_job(16'd1);

      // count zero is taken as one machine
      set_machine_count(5'd0);
      send_job(16'd7);
      send_job(16'd0);

      // count above range is taken as sixteen; equal lengths give equal free times
      set_machine_count(5'd31);
      for (k = 0; k < 10; k++) send_job(16'd9);
      send_job(16'hFFFF);

      // random phases over several counts and idle patterns
      for (phase = 0; phase < 9; phase++) begin
         if (phase < 8) count_value = gma_pkg::COUNT_BITS'(PHASE_COUNTS[phase]);
         else count_value = gma_pkg::COUNT_BITS'($urandom_range(0, 31));
         set_machine_count(count_value);
         req_idle_on = (phase % 4 != 3);
         rsp_idle_on = (phase % 4 != 2);
         // result side holds off while jobs keep coming
         if (phase == 1) begin
            req_idle_on = 1'b0;
            hold_off    = HOLD_CYCLES;
         end
         for (k = 0; k < PHASE_ITEMS; k++) send_job(pick_length());
      end

      // one machine, back to back with no idling
      set_machine_count(5'd1);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      send_job(16'd40000);
      send_job(16'd30000);
      send_job(16'd1);
      send_job(16'd0);
      send_job(16'hFFFF);

      // drain and settle
      req_bus.valid <= 1'b0;
      while (board.pending_count() > 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (board.mismatches == 0 && board.pending_count() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end
endmodule

>>> files.f
sv/gma_pkg.sv
sv/gma_req_if.sv
sv/gma_rsp_if.sv
sv/gma_heap_mem.sv
sv/greedy_machine_assigner.sv
verif/testbench.sv
